// File: sv/rgb_to_hsv_converter_top_macros.svh
// Assertion macros for the RGB to HSV converter checker.
// No dependencies.
`ifndef RGB_TO_HSV_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_TOP_MACROS_SVH
// implication checked every clock, disabled in reset
`define RHC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define RHC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: sv/rhc_pkg.sv
// Package for the RGB to HSV converter: payload types, constants.
// No dependencies.
`timescale 1ns / 1ps
package rhc_pkg;
    localparam int HueSixty = 3840;
    localparam int HueFull  = 23040;
    localparam int DivSteps = 17;
    localparam int QDepth = 4;
    localparam int QAW = 2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [14:0] hue_angle;
        logic [15:0] saturation;
        logic [7:0]  brightness;
    } hsv_t;

    typedef enum logic [1:0] {
        SEC_GREY  = 2'd0,
        SEC_RED   = 2'd1,
        SEC_GREEN = 2'd2,
        SEC_BLUE  = 2'd3
    } sector_t;

    // classified item handed from front to back
    typedef struct packed {
        sector_t     sector;
        logic        neg;       // set when the first hue term is below the second (green < blue in red sector)
        logic [7:0]  diff;      // |channel difference| for hue numerator
        logic [7:0]  d;         // max - min
        logic [7:0]  mx;
    } cls_t;
endpackage

// File: sv/rhc_front.sv
// Front: finds max, min, sector and hue numerator terms of a pixel.
// Depends on rhc_pkg.
`timescale 1ns / 1ps
module rhc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  rhc_pkg::pixel_t pix,
    input  logic           in_valid,
    output rhc_pkg::cls_t  cls,
    output logic           out_valid
);
    import rhc_pkg::*;
    logic [7:0] mx, mn, a, b;
    sector_t sec;
    cls_t cls_reg, cls_next;
    logic valid_reg;

    always_comb
    begin
        mx = pix.red;
        mn = pix.red;
        if (pix.green > mx) mx = pix.green;
        if (pix.blue > mx) mx = pix.blue;
        if (pix.green < mn) mn = pix.green;
        if (pix.blue < mn) mn = pix.blue;
        if (mx == mn)
        begin
            sec = SEC_GREY; a = 8'd0; b = 8'd0;
        end
        else if (mx == pix.blue)
        begin
            sec = SEC_BLUE; a = pix.red; b = pix.green;
        end
        else if (mx == pix.green)
        begin
            sec = SEC_GREEN; a = pix.blue; b = pix.red;
        end
        else
        begin
            sec = SEC_RED; a = pix.green; b = pix.blue;
        end
        cls_next.sector = sec;
        cls_next.neg    = (a < b);
        cls_next.diff   = (a < b) ? (b - a) : (a - b);
        cls_next.d      = mx - mn;
        cls_next.mx     = mx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            cls_reg <= cls_next;
    end

    assign cls = cls_reg;
    assign out_valid = valid_reg;
endmodule

// File: sv/rhc_queue.sv
// Short FIFO of classified pixels between front and back.
// Depends on rhc_pkg.
`timescale 1ns / 1ps
module rhc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  rhc_pkg::cls_t wdata,
    input  logic          rd,
    output rhc_pkg::cls_t rdata,
    output logic          empty
);
    import rhc_pkg::*;
    // back drains every cycle it sees an entry, so occupancy never exceeds one
    cls_t mem [QDepth];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAW+1)'(wr) - (QAW+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem[wp_reg] <= wdata;
    end

    assign rdata = mem[rp_reg];
    assign empty = (cnt_reg == '0);
endmodule

// File: sv/rhc_back.sv
// Back: pipelined restoring dividers for hue and saturation, one pixel per clock.
// Depends on rhc_pkg.
`timescale 1ns / 1ps
module rhc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  rhc_pkg::cls_t cls,
    input  logic          in_valid,
    output rhc_pkg::hsv_t res,
    output logic          out_valid
);
    import rhc_pkg::*;
    // per stage: hue dividend 3840*diff (20b), sat dividend d*65535 (24b)
    typedef struct packed {
        logic [23:0] snum;
        logic [19:0] hnum;
        logic [16:0] sq;
        logic [16:0] hq;
        logic [8:0]  srem;
        logic [8:0]  hrem;
        sector_t     sector;
        logic        neg;
        logic [7:0]  d;
        logic [7:0]  mx;
    } stg_t;

    stg_t st_reg [DivSteps+1];
    logic [DivSteps:0] v_reg;
    stg_t st_next [DivSteps+1];
    logic [14:0] hue;
    logic [15:0] hoff;
    logic [15:0] hq16;
    logic        hadj;

    always_comb
    begin
        st_next[0].snum   = 24'(cls.d) * 24'd65535;
        st_next[0].hnum   = 20'(cls.diff) * 20'(HueSixty);
        st_next[0].sq     = '0;
        st_next[0].hq     = '0;
        st_next[0].srem   = '0;
        st_next[0].hrem   = '0;
        st_next[0].sector = cls.sector;
        st_next[0].neg    = cls.neg;
        st_next[0].d      = cls.d;
        st_next[0].mx     = cls.mx;
        for (int i = 1; i <= DivSteps; i++)
        begin
            logic [8:0] sr, hr;
            st_next[i] = st_reg[i-1];
            // sat: shift in 24 bits over 17 steps -> first step takes 8 bits
            if (i == 1)
            begin
                sr = {1'b0, st_reg[0].snum[23:16]};
                hr = {5'b0, st_reg[0].hnum[19:16]};
            end
            else
            begin
                sr = {st_reg[i-1].srem[7:0], st_reg[i-1].snum[16-i+1]};
                hr = {st_reg[i-1].hrem[7:0], st_reg[i-1].hnum[16-i+1]};
            end
            if (i == 1)
            begin
                st_next[i].srem = (st_reg[0].mx != 0 && sr >= {1'b0, st_reg[0].mx})
                    ? sr - {1'b0, st_reg[0].mx} : sr;
                st_next[i].hrem = (st_reg[0].d != 0 && hr >= {1'b0, st_reg[0].d})
                    ? hr - {1'b0, st_reg[0].d} : hr;
            end
            else
            begin
                st_next[i].sq = {st_reg[i-1].sq[15:0],
                                 (sr >= {1'b0, st_reg[i-1].mx})};
                st_next[i].hq = {st_reg[i-1].hq[15:0],
                                 (hr >= {1'b0, st_reg[i-1].d})};
                st_next[i].srem = (sr >= {1'b0, st_reg[i-1].mx})
                    ? sr - {1'b0, st_reg[i-1].mx} : sr;
                st_next[i].hrem = (hr >= {1'b0, st_reg[i-1].d})
                    ? hr - {1'b0, st_reg[i-1].d} : hr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[DivSteps-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= DivSteps; i++)
            st_reg[i] <= st_next[i];
    end

    // quotients: dividend bits 15..0 remain after first step leaves high part as
    // remainder (< divisor since quotient of high part is 0 given d*65535/mx <= 65535).
    always_comb
    begin
        hq16 = st_reg[DivSteps].hq[15:0];
        case (st_reg[DivSteps].sector)
            SEC_BLUE:  hoff = 16'd15360;
            SEC_GREEN: hoff = 16'd7680;
            SEC_RED:   hoff = st_reg[DivSteps].neg ? 16'(HueFull) : 16'd0;
            default:   hoff = 16'd0;
        endcase
        // blue/green numerators stay positive, so a negative term rounds up
        hadj = (st_reg[DivSteps].sector != SEC_RED) && (st_reg[DivSteps].hrem != '0);
        if (st_reg[DivSteps].sector == SEC_GREY)
            hue = '0;
        else if (st_reg[DivSteps].neg)
            hue = 15'(hoff - hq16 - 16'(hadj));
        else
            hue = 15'(hoff + hq16);
        res.hue_angle  = hue;
        res.saturation = (st_reg[DivSteps].mx == 0) ? 16'd0 : st_reg[DivSteps].sq[15:0];
        res.brightness = st_reg[DivSteps].mx;
    end

    assign out_valid = v_reg[DivSteps];
endmodule

// File: sv/rgb_to_hsv_converter_top.sv
// Top level of the RGB to HSV converter.
// Depends on rhc_pkg, rhc_front, rhc_queue, rhc_back.
`timescale 1ns / 1ps
// Usage:
//  Input channel is a queue push port: drive a pixel and push; it is taken
//  on a clock edge where push is high and full is low.
//  Output channel is a queue pop port: while empty is low the oldest result
//  (hue_angle, saturation, brightness) is on result; pop takes it.
//  Throughput: one pixel per clock while full is low. The front registers
//  its classification, a short queue passes it on, and the back runs a
//  17-stage pipelined divider.
//  The output queue holds every result still in flight, so full rises when
//  results in queue plus pixels in the pipe reach its depth; a stalled
//  receiver then stops intake, and no result is dropped.
//  Reset (rst_n low, asynchronous) empties the pipe and queue.
module rgb_to_hsv_converter_top (
    input  logic            clk,
    input  logic            rst_n,
    input  rhc_pkg::pixel_t pixel,
    input  logic            push,
    output logic            full,
    output rhc_pkg::hsv_t   result,
    output logic            empty,
    input  logic            pop
);
    import rhc_pkg::*;
    localparam int Lat = DivSteps + 3;
    localparam int OD = 32;
    localparam int OAW = 5;

    cls_t cls, cls_q;
    logic cls_v, q_empty, q_rd, res_v, acc, take;
    hsv_t res;
    logic [OAW:0] credit_reg;
    hsv_t omem [OD];
    logic [OAW-1:0] wp_reg, rp_reg;
    logic [OAW:0] cnt_reg;

    assign acc  = push && !full;
    assign take = pop && !empty;
    assign q_rd = !q_empty;
    // credits cover pipe occupancy plus queued results
    assign full = (credit_reg == (OAW+1)'(OD));

    rhc_front u_front (
        .clk(clk), .rst_n(rst_n), .pix(pixel), .in_valid(acc),
        .cls(cls), .out_valid(cls_v)
    );
    rhc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(cls_v), .wdata(cls),
        .rd(q_rd), .rdata(cls_q), .empty(q_empty)
    );
    rhc_back u_back (
        .clk(clk), .rst_n(rst_n), .cls(cls_q), .in_valid(q_rd),
        .res(res), .out_valid(res_v)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_reg + (OAW+1)'(acc) - (OAW+1)'(take);
            if (res_v) wp_reg <= wp_reg + 1'b1;
            if (take) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (OAW+1)'(res_v) - (OAW+1)'(take);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_v) omem[wp_reg] <= res;
    end

    assign result = omem[rp_reg];
    assign empty = (cnt_reg == '0) || (Lat == 0);
endmodule

// File: sv/rhc_checker.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on rhc_pkg and rgb_to_hsv_converter_top_macros.svh.
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_top_macros.svh"
module rhc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            push,
    input logic            full,
    input logic            empty,
    input logic            pop,
    input rhc_pkg::hsv_t   result
);
    import rhc_pkg::*;
    `RHC_ASSERT_IMP(hue_range, !empty, result.hue_angle < 15'(HueFull))
    `RHC_ASSERT_IMP(black_sat, !empty && result.brightness == 8'd0, result.saturation == 16'd0)
    `RHC_ASSERT_NXT(held_result, !empty && !pop, !empty && $stable(result))
endmodule

bind rgb_to_hsv_converter_top rhc_checker u_rhc_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .empty(empty), .pop(pop), .result(result)
);
